FILE: rtl/attitude_pid_motor_mixer_core_defines.svh
// Assertion macros shared by the checker files of the attitude PID motor mixer.
// Each macro expects signals named aclk and aresetn in the scope where it is used.
`ifndef ATTITUDE_PID_MOTOR_MIXER_CORE_DEFINES_SVH
`define ATTITUDE_PID_MOTOR_MIXER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/apm_pkg.sv
// Shared types and constants of the attitude PID motor mixer.
// Used by every module of the block; depends on nothing.
package apm_pkg;

    localparam int AXES       = 3;
    localparam int MOTORS     = 4;
    localparam int ANGLE_W    = 15;
    localparam int ERR_W      = 16;
    localparam int SUM_W      = 32;
    localparam int DIFF_W     = 17;
    localparam int GAIN_W     = 32;
    localparam int WIDTH_W    = 18;
    localparam int GAIN_SHIFT = 22;

    // Product widths: unsigned gain (as 33-bit signed) times signed operand.
    localparam int PROD_P_W = 49;
    localparam int PROD_I_W = 64;
    localparam int PROD_D_W = 50;

    // Terms after the floor shift by GAIN_SHIFT.
    localparam int TERM_P_W = PROD_P_W - GAIN_SHIFT;
    localparam int TERM_I_W = PROD_I_W - GAIN_SHIFT;
    localparam int TERM_D_W = PROD_D_W - GAIN_SHIFT;

    localparam int AXIS_W = 43;
    localparam int MIX_W  = 46;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 72;
    localparam int CFG_ADDR_W = 3;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic [WIDTH_W-1:0]        width_t;
    typedef logic signed [TERM_P_W-1:0] term_p_t;
    typedef logic signed [TERM_I_W-1:0] term_i_t;
    typedef logic signed [TERM_D_W-1:0] term_d_t;
    typedef logic signed [AXIS_W-1:0]   axis_t;
    typedef logic signed [MIX_W-1:0]    mix_t;
    typedef logic [CFG_ADDR_W-1:0]      cfg_idx_t;

    localparam sum_t SUM_MAX = 32'sh7FFF_FFFF;
    localparam sum_t SUM_MIN = 32'sh8000_0000;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_PROP_GAIN     = 3'd0;
    localparam cfg_idx_t REG_INTEG_GAIN    = 3'd1;
    localparam cfg_idx_t REG_DERIV_GAIN    = 3'd2;
    localparam cfg_idx_t REG_PITCH_TARGET  = 3'd3;
    localparam cfg_idx_t REG_ROLL_TARGET   = 3'd4;
    localparam cfg_idx_t REG_YAW_TARGET    = 3'd5;
    localparam cfg_idx_t REG_WIDTH_FLOOR   = 3'd6;
    localparam cfg_idx_t REG_WIDTH_CEILING = 3'd7;

    localparam gain_t  PROP_GAIN_RST     = 32'd65536000;
    localparam width_t WIDTH_FLOOR_RST   = 18'd105000;
    localparam width_t WIDTH_CEILING_RST = 18'd170000;

    typedef struct packed {
        gain_t prop_gain;
        gain_t integ_gain;
        gain_t deriv_gain;
    } gains_t;

    // Load enables of the two register ranks inside the gain stage.
    typedef struct packed {
        logic prod_ld;
        logic sum_ld;
    } gain_ctl_t;

endpackage

FILE: rtl/apm_err_stage.sv
// Error, saturating integrator and error difference for the three axes.
// Holds the loop state (error sums, previous errors); uses apm_pkg.
module apm_err_stage
    import apm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  angle_t target [AXES],
    input  angle_t angle  [AXES],
    output err_t   err_out  [AXES],
    output sum_t   sum_out  [AXES],
    output diff_t  diff_out [AXES]
);

    sum_t  sum_reg  [AXES];
    err_t  last_reg [AXES];
    err_t  err_reg  [AXES];
    diff_t diff_reg [AXES];

    err_t  err_next  [AXES];
    sum_t  sum_next  [AXES];
    diff_t diff_next [AXES];
    logic signed [SUM_W:0] sum_wide [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            err_next[a] = err_t'(target[a]) - err_t'(angle[a]);
            sum_wide[a] = (SUM_W+1)'(sum_reg[a]) + (SUM_W+1)'(err_next[a]);
            // Overflow shows as the two top bits of the widened sum differing.
            if (sum_wide[a][SUM_W] != sum_wide[a][SUM_W-1]) begin
                sum_next[a] = sum_wide[a][SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                sum_next[a] = sum_wide[a][SUM_W-1:0];
            end
            diff_next[a] = diff_t'(err_next[a]) - diff_t'(last_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a]  <= '0;
                last_reg[a] <= '0;
            end
        end else if (load) begin
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a]  <= sum_next[a];
                last_reg[a] <= err_next[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int a = 0; a < AXES; a++) begin
                err_reg[a]  <= err_next[a];
                diff_reg[a] <= diff_next[a];
            end
        end
    end

    assign err_out  = err_reg;
    assign sum_out  = sum_reg;
    assign diff_out = diff_reg;

endmodule

FILE: rtl/apm_gain_stage.sv
// Gain multiplications and per-axis P + I + D sums, two register ranks.
// Products are floor-shifted by the gain fraction; uses apm_pkg.
module apm_gain_stage
    import apm_pkg::*;
(
    input  logic      aclk,
    input  gain_ctl_t ctl,
    input  gains_t    gains,
    input  err_t      err  [AXES],
    input  sum_t      sum  [AXES],
    input  diff_t     diff [AXES],
    output axis_t     axis_term [AXES]
);

    logic signed [PROD_P_W-1:0] p_prod [AXES];
    logic signed [PROD_I_W-1:0] i_prod [AXES];
    logic signed [PROD_D_W-1:0] d_prod [AXES];

    term_p_t p_reg [AXES];
    term_i_t i_reg [AXES];
    term_d_t d_reg [AXES];
    axis_t   axis_reg [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            p_prod[a] = PROD_P_W'($signed({1'b0, gains.prop_gain})) * PROD_P_W'(err[a]);
            i_prod[a] = PROD_I_W'($signed({1'b0, gains.integ_gain})) * PROD_I_W'(sum[a]);
            d_prod[a] = PROD_D_W'($signed({1'b0, gains.deriv_gain})) * PROD_D_W'(diff[a]);
        end
    end

    // Dropping the low bits of a two's complement product rounds toward minus infinity.
    always_ff @(posedge aclk) begin
        if (ctl.prod_ld) begin
            for (int a = 0; a < AXES; a++) begin
                p_reg[a] <= p_prod[a][PROD_P_W-1:GAIN_SHIFT];
                i_reg[a] <= i_prod[a][PROD_I_W-1:GAIN_SHIFT];
                d_reg[a] <= d_prod[a][PROD_D_W-1:GAIN_SHIFT];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_ld) begin
            for (int a = 0; a < AXES; a++) begin
                axis_reg[a] <= axis_t'(p_reg[a]) + axis_t'(i_reg[a]) + axis_t'(d_reg[a]);
            end
        end
    end

    assign axis_term = axis_reg;

endmodule

FILE: rtl/apm_mixer.sv
// X-frame motor mixer with floor and ceiling clamp, ending in the result register.
// Axis terms arrive in pitch, roll, yaw order; uses apm_pkg.
module apm_mixer
    import apm_pkg::*;
(
    input  logic   aclk,
    input  logic   load,
    input  axis_t  axis_term [AXES],
    input  width_t width_floor,
    input  width_t width_ceiling,
    output width_t motor [MOTORS]
);

    function automatic width_t clamp_width(mix_t v, mix_t lo, mix_t hi);
        mix_t r;
        r = v;
        if (r < lo) begin
            r = lo;
        end
        // Applied last, so a ceiling below the floor wins.
        if (r > hi) begin
            r = hi;
        end
        return r[WIDTH_W-1:0];
    endfunction

    mix_t   base;
    mix_t   top;
    mix_t   p;
    mix_t   r;
    mix_t   y;
    width_t motor_next [MOTORS];
    width_t motor_reg  [MOTORS];

    always_comb begin
        base = mix_t'($signed({1'b0, width_floor}));
        top  = mix_t'($signed({1'b0, width_ceiling}));
        p    = mix_t'(axis_term[0]);
        r    = mix_t'(axis_term[1]);
        y    = mix_t'(axis_term[2]);
        motor_next[0] = clamp_width(base + p + r + y, base, top);
        motor_next[1] = clamp_width(base - p + r - y, base, top);
        motor_next[2] = clamp_width(base - p - r + y, base, top);
        motor_next[3] = clamp_width(base + p - r - y, base, top);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            motor_reg <= motor_next;
        end
    end

    assign motor = motor_reg;

endmodule

FILE: rtl/attitude_pid_motor_mixer_core.sv
// Attitude PID controller with X-frame motor mixer, top level.
// Holds the configuration registers, input register and pipeline flow control;
// instantiates apm_err_stage, apm_gain_stage and apm_mixer; uses apm_pkg.
//
// Usage: each input word on s_t* carries one measured pitch, roll and yaw sample.
// The block forms the three PID axis terms and returns one result word on m_t*
// with four motor pulse widths, clamped between width_floor and width_ceiling.
// Configuration (gains, setpoints, width limits) is written through cfg_we, cfg_addr
// and cfg_wdata, by the user only while no word is in flight; the block does not enforce it.
//
// From the accepting edge to m_tvalid the word passes the input register,
// error/integrator register, product register, axis sum register and result register.
// Throughput is one word per cycle while m_tready is high; the integrator update is
// a single saturating add, so each sample sees the state left by the one before it.
//
// Reset clears the pipeline valid flags, the integrators and previous errors,
// and loads the default configuration. When the receiver holds m_tready low the
// result word stays on m_tdata, and earlier stages keep filling until every
// register holds a word; only then does s_tready drop.
module attitude_pid_motor_mixer_core
    import apm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // pitch_angle, roll_angle, yaw_angle, zero pad
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // motor_front, motor_second, motor_third, motor_fourth
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    // Configuration registers.
    gains_t gains_reg;
    angle_t target_reg [AXES];
    width_t floor_reg;
    width_t ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.prop_gain  <= PROP_GAIN_RST;
            gains_reg.integ_gain <= '0;
            gains_reg.deriv_gain <= '0;
            for (int a = 0; a < AXES; a++) begin
                target_reg[a] <= '0;
            end
            floor_reg   <= WIDTH_FLOOR_RST;
            ceiling_reg <= WIDTH_CEILING_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PROP_GAIN:     gains_reg.prop_gain  <= cfg_wdata;
                REG_INTEG_GAIN:    gains_reg.integ_gain <= cfg_wdata;
                REG_DERIV_GAIN:    gains_reg.deriv_gain <= cfg_wdata;
                REG_PITCH_TARGET:  target_reg[0] <= cfg_wdata[ANGLE_W-1:0];
                REG_ROLL_TARGET:   target_reg[1] <= cfg_wdata[ANGLE_W-1:0];
                REG_YAW_TARGET:    target_reg[2] <= cfg_wdata[ANGLE_W-1:0];
                REG_WIDTH_FLOOR:   floor_reg     <= cfg_wdata[WIDTH_W-1:0];
                REG_WIDTH_CEILING: ceiling_reg   <= cfg_wdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control. A stage is free when it is empty or its word
    // moves on in this cycle; it then takes whatever the stage before holds.
    logic in_vld_reg, err_vld_reg, prod_vld_reg, axis_vld_reg, out_vld_reg;
    logic free_in, free_err, free_prod, free_axis, free_out;

    assign free_out  = !out_vld_reg  || m_tready;
    assign free_axis = !axis_vld_reg || free_out;
    assign free_prod = !prod_vld_reg || free_axis;
    assign free_err  = !err_vld_reg  || free_prod;
    assign free_in   = !in_vld_reg   || free_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            err_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            axis_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (free_in)   in_vld_reg   <= s_tvalid;
            if (free_err)  err_vld_reg  <= in_vld_reg;
            if (free_prod) prod_vld_reg <= err_vld_reg;
            if (free_axis) axis_vld_reg <= prod_vld_reg;
            if (free_out)  out_vld_reg  <= axis_vld_reg;
        end
    end

    logic      err_ld;
    logic      out_ld;
    gain_ctl_t gain_ctl;

    assign err_ld           = in_vld_reg   && free_err;
    assign gain_ctl.prod_ld = err_vld_reg  && free_prod;
    assign gain_ctl.sum_ld  = prod_vld_reg && free_axis;
    assign out_ld           = axis_vld_reg && free_out;

    // Input register.
    angle_t angle_reg [AXES];

    always_ff @(posedge aclk) begin
        if (s_tvalid && free_in) begin
            for (int a = 0; a < AXES; a++) begin
                angle_reg[a] <= s_tdata[a*ANGLE_W +: ANGLE_W];
            end
        end
    end

    err_t   err_q  [AXES];
    sum_t   sum_q  [AXES];
    diff_t  diff_q [AXES];
    axis_t  axis_q [AXES];
    width_t motor  [MOTORS];

    apm_err_stage u_err (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (err_ld),
        .target   (target_reg),
        .angle    (angle_reg),
        .err_out  (err_q),
        .sum_out  (sum_q),
        .diff_out (diff_q)
    );

    apm_gain_stage u_gain (
        .aclk      (aclk),
        .ctl       (gain_ctl),
        .gains     (gains_reg),
        .err       (err_q),
        .sum       (sum_q),
        .diff      (diff_q),
        .axis_term (axis_q)
    );

    apm_mixer u_mix (
        .aclk          (aclk),
        .load          (out_ld),
        .axis_term     (axis_q),
        .width_floor   (floor_reg),
        .width_ceiling (ceiling_reg),
        .motor         (motor)
    );

    assign s_tready = free_in;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {motor[3], motor[2], motor[1], motor[0]};

endmodule

FILE: rtl/apm_port_checker.sv
// Port-level checks of the attitude PID motor mixer, bound to the top level.
// Uses the assertion macros of attitude_pid_motor_mixer_core_defines.svh.
`include "attitude_pid_motor_mixer_core_defines.svh"

module apm_port_checker
    import apm_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result word stays put.
    `APM_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // With the result register empty, every stage has room for a new word.
    `APM_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // A receiver that takes the result frees the whole pipeline.
    `APM_ASSERT_NOW(a_ready_when_drained, m_tready, s_tready, "input stalled while output drains")

    // An input word offered while ready must be absorbed, never backpressure next cycle
    // unless the output is full and stalled.
    `APM_ASSERT_NEXT(a_stall_needs_full, s_tvalid && s_tready && !m_tready, s_tready || m_tvalid, "input stalled without a pending result")

endmodule

bind attitude_pid_motor_mixer_core apm_port_checker u_apm_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
